// ===== rtl/bpc_pkg.sv =====
// shared constants and types for the barometric pressure compensation block
package bpc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2_AC3 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AC4_AC5_AC6 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1_B2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MC_MD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS         = 3'd4;

    // field widths
    localparam int RAW_T_W = 16;
    localparam int RAW_P_W = 19;
    localparam int TEMP_W  = 16;
    localparam int PRES_W  = 20;

    // divider widths: mc * 2048 magnitude, then the full 32-bit pressure quotient
    localparam int DIV1_NUM_W = 27;
    localparam int DIV2_NUM_W = 32;
    localparam int DIV_DEN_W  = 32;

    // compensation constants
    localparam logic signed [31:0] C_B6_OFS    = 32'sd4000;
    localparam logic        [31:0] C_X3_OFS    = 32'd32768;
    localparam logic        [16:0] C_OSS_BASE  = 17'd50000;
    localparam logic signed [31:0] C_K1        = 32'sd3038;
    localparam logic signed [31:0] C_K2        = -32'sd7357;
    localparam logic signed [31:0] C_K3        = 32'sd3791;
    localparam logic signed [31:0] C_P_MAX     = 32'sd1048575;
    localparam logic signed [31:0] C_T_MAX     = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN     = -32'sd32768;

    // sideband carried through the temperature divider
    typedef struct packed {
        logic signed [31:0]  x1;
        logic                neg;
        logic                err;
        logic [RAW_P_W-1:0]  up;
    } t_d1_side;

    // sideband carried through the pressure divider
    typedef struct packed {
        logic signed [TEMP_W-1:0] t;
        logic                     err;
        logic                     big;
    } t_d2_side;

endpackage

// ===== rtl/barometric_pressure_compensation_top.sv =====
// barometric pressure compensation pipeline, top level
// Takes one raw temperature / raw pressure beat per cycle while o_stall is low,
// returns compensated temperature (0.1 degree steps) and pressure (pascal), one
// result per cycle unless the output stalls. Two pipelined dividers (27 stages
// for the temperature term, 32 for pressure) plus 14 arithmetic stages set the
// depth. The whole pipeline advances together and holds only while a finished
// result sits unaccepted on the output. The user must write coefficients and
// oversampling via the config port only while no beat is in flight; the block
// does not enforce it. A zero divisor sets divide_error and zeroes both values.
module barometric_pressure_compensation_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bpc_pkg::RAW_T_W-1:0]       i_raw_temperature,
    input  logic [bpc_pkg::RAW_P_W-1:0]       i_raw_pressure,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [bpc_pkg::TEMP_W-1:0] o_temperature_decidegrees,
    output logic [bpc_pkg::PRES_W-1:0]        o_pressure_pascal,
    output logic                              o_divide_error
);

    // config registers
    logic [47:0] r_cfg_ac123;
    logic [47:0] r_cfg_ac456;
    logic [31:0] r_cfg_b12;
    logic [31:0] r_cfg_mcmd;
    logic [1:0]  r_cfg_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ac123 <= '0;
            r_cfg_ac456 <= '0;
            r_cfg_b12   <= '0;
            r_cfg_mcmd  <= '0;
            r_cfg_oss   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpc_pkg::CFG_AC1_AC2_AC3: r_cfg_ac123 <= i_cfg_wdata;
                bpc_pkg::CFG_AC4_AC5_AC6: r_cfg_ac456 <= i_cfg_wdata;
                bpc_pkg::CFG_B1_B2:       r_cfg_b12   <= i_cfg_wdata[31:0];
                bpc_pkg::CFG_MC_MD:       r_cfg_mcmd  <= i_cfg_wdata[31:0];
                bpc_pkg::CFG_OSS:         r_cfg_oss   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [15:0] ac4, ac5, ac6;

    assign ac1 = r_cfg_ac123[47:32];
    assign ac2 = r_cfg_ac123[31:16];
    assign ac3 = r_cfg_ac123[15:0];
    assign ac4 = r_cfg_ac456[47:32];
    assign ac5 = r_cfg_ac456[31:16];
    assign ac6 = r_cfg_ac456[15:0];
    assign b1  = r_cfg_b12[31:16];
    assign b2  = r_cfg_b12[15:0];
    assign mc  = r_cfg_mcmd[31:16];
    assign md  = r_cfg_mcmd[15:0];

    // global advance: hold only when the output beat is stalled
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage valid bits
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld, r_m_vld, r_o_vld;
    logic d1_vld, d2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_b_vld <= 1'b0; r_c_vld <= 1'b0; r_d_vld <= 1'b0;
            r_e_vld <= 1'b0; r_f_vld <= 1'b0; r_g_vld <= 1'b0; r_h_vld <= 1'b0;
            r_i_vld <= 1'b0; r_j_vld <= 1'b0; r_k_vld <= 1'b0; r_l_vld <= 1'b0;
            r_m_vld <= 1'b0; r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= d1_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= d2_vld;
            r_l_vld <= r_k_vld;
            r_m_vld <= r_l_vld;
            r_o_vld <= r_m_vld;
        end
    end

    // stage a: (ut - ac6) * ac5
    logic signed [17:0] a_diff;
    logic signed [34:0] a_prod;
    logic signed [31:0] r_a_prod;
    logic [bpc_pkg::RAW_P_W-1:0] r_a_up;

    always_comb begin
        a_diff = $signed({2'b00, i_raw_temperature}) - $signed({2'b00, ac6});
        a_prod = a_diff * $signed({1'b0, ac5});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= a_prod[31:0];
            r_a_up   <= i_raw_pressure;
        end
    end

    // stage b: x1, divisor x1 + md, signed operands to magnitudes
    logic signed [31:0] b_x1, b_den;
    logic signed [26:0] b_num;
    logic [26:0]        b_numabs;
    logic [31:0]        b_denabs;
    bpc_pkg::t_d1_side  b_side;
    bpc_pkg::t_d1_side  r_b_side;
    logic [26:0]        r_b_num;
    logic [31:0]        r_b_den;

    always_comb begin
        b_x1        = r_a_prod >>> 15;
        b_den       = b_x1 + 32'(md);
        b_num       = {mc, 11'b0};
        b_numabs    = mc[15] ? $unsigned(-b_num) : $unsigned(b_num);
        b_denabs    = b_den[31] ? $unsigned(-b_den) : $unsigned(b_den);
        b_side.x1   = b_x1;
        b_side.neg  = mc[15] ^ b_den[31];
        b_side.err  = (b_den == 32'sd0);
        b_side.up   = r_a_up;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side <= b_side;
            r_b_num  <= b_numabs;
            r_b_den  <= b_denabs;
        end
    end

    // temperature divider: mc * 2048 / (x1 + md)
    logic [26:0]                        d1_quo;
    logic [$bits(bpc_pkg::t_d1_side)-1:0] d1_side_raw;
    bpc_pkg::t_d1_side                  d1_side;

    bpc_div_pipe #(
        .NUM_W  (bpc_pkg::DIV1_NUM_W),
        .DEN_W  (bpc_pkg::DIV_DEN_W),
        .SIDE_W ($bits(bpc_pkg::t_d1_side))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_side  (r_b_side),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side_raw)
    );

    assign d1_side = d1_side_raw;

    // stage c: restore sign, b5 = x1 + x2
    logic signed [31:0] c_q, c_x2;
    logic signed [31:0] r_c_b5;
    logic               r_c_err;
    logic [bpc_pkg::RAW_P_W-1:0] r_c_up;

    always_comb begin
        c_q  = $signed({5'b0, d1_quo});
        c_x2 = d1_side.neg ? -c_q : c_q;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_b5  <= d1_side.x1 + c_x2;
            r_c_err <= d1_side.err;
            r_c_up  <= d1_side.up;
        end
    end

    // stage d: b6 and saturated temperature
    logic signed [31:0] d_tw;
    logic signed [15:0] d_t;
    logic signed [31:0] r_d_b6;
    logic signed [15:0] r_d_t;
    logic               r_d_err;
    logic [bpc_pkg::RAW_P_W-1:0] r_d_up;

    always_comb begin
        d_tw = (r_c_b5 + 32'sd8) >>> 4;
        if (d_tw > bpc_pkg::C_T_MAX) begin
            d_t = 16'sh7FFF;
        end else if (d_tw < bpc_pkg::C_T_MIN) begin
            d_t = 16'sh8000;
        end else begin
            d_t = d_tw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_b6  <= r_c_b5 - bpc_pkg::C_B6_OFS;
            r_d_t   <= d_t;
            r_d_err <= r_c_err;
            r_d_up  <= r_c_up;
        end
    end

    // stage e: b6 squared, ac2 * b6, ac3 * b6
    logic signed [31:0] r_e_sq, r_e_m2, r_e_m3;
    logic signed [15:0] r_e_t;
    logic               r_e_err;
    logic [bpc_pkg::RAW_P_W-1:0] r_e_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_sq  <= r_d_b6 * r_d_b6;
            r_e_m2  <= 32'(ac2) * r_d_b6;
            r_e_m3  <= 32'(ac3) * r_d_b6;
            r_e_t   <= r_d_t;
            r_e_err <= r_d_err;
            r_e_up  <= r_d_up;
        end
    end

    // stage f: b2 * sq and b1 * sq
    logic signed [31:0] f_sq;
    logic signed [31:0] r_f_pb2, r_f_pb1, r_f_x2a, r_f_x1c;
    logic signed [15:0] r_f_t;
    logic               r_f_err;
    logic [bpc_pkg::RAW_P_W-1:0] r_f_up;

    assign f_sq = r_e_sq >>> 12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_pb2 <= 32'(b2) * f_sq;
            r_f_pb1 <= 32'(b1) * f_sq;
            r_f_x2a <= r_e_m2 >>> 11;
            r_f_x1c <= r_e_m3 >>> 13;
            r_f_t   <= r_e_t;
            r_f_err <= r_e_err;
            r_f_up  <= r_e_up;
        end
    end

    // stage g: b3 and the b4 multiplicand
    logic signed [31:0] g_x3, g_b3a, g_b3s, g_b3p, g_b3, g_x3b;
    logic signed [31:0] r_g_b3;
    logic [31:0]        r_g_xs;
    logic signed [15:0] r_g_t;
    logic               r_g_err;
    logic [bpc_pkg::RAW_P_W-1:0] r_g_up;

    always_comb begin
        g_x3  = (r_f_pb2 >>> 11) + r_f_x2a;
        g_b3a = (32'(ac1) <<< 2) + g_x3;
        g_b3s = g_b3a <<< r_cfg_oss;
        g_b3p = g_b3s + 32'sd2;
        // divide by four, rounding toward zero
        g_b3  = (g_b3p + (g_b3p[31] ? 32'sd3 : 32'sd0)) >>> 2;
        g_x3b = (r_f_x1c + (r_f_pb1 >>> 16) + 32'sd2) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_b3  <= g_b3;
            r_g_xs  <= $unsigned(g_x3b) + bpc_pkg::C_X3_OFS;
            r_g_t   <= r_f_t;
            r_g_err <= r_f_err;
            r_g_up  <= r_f_up;
        end
    end

    // stage h: b4 and up - b3
    logic [31:0]        h_prod;
    logic [31:0]        r_h_b4, r_h_diff;
    logic signed [15:0] r_h_t;
    logic               r_h_err;

    assign h_prod = {16'b0, ac4} * r_g_xs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_b4   <= h_prod >> 15;
            r_h_diff <= {13'b0, r_g_up} - $unsigned(r_g_b3);
            r_h_t    <= r_g_t;
            r_h_err  <= r_g_err;
        end
    end

    // stage i: b7
    logic [16:0]        i_oss_k;
    logic [31:0]        r_i_b7, r_i_b4;
    logic signed [15:0] r_i_t;
    logic               r_i_err;

    assign i_oss_k = bpc_pkg::C_OSS_BASE >> r_cfg_oss;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_b7  <= r_h_diff * {15'b0, i_oss_k};
            r_i_b4  <= r_h_b4;
            r_i_t   <= r_h_t;
            r_i_err <= r_h_err;
        end
    end

    // stage j: zero check and dividend for the pressure divider
    bpc_pkg::t_d2_side j_side;
    bpc_pkg::t_d2_side r_j_side;
    logic [31:0]       r_j_num, r_j_den;

    always_comb begin
        j_side.t   = r_i_t;
        j_side.err = r_i_err || (r_i_b4 == 32'd0);
        j_side.big = r_i_b7[31];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_side <= j_side;
            r_j_num  <= r_i_b7[31] ? r_i_b7 : {r_i_b7[30:0], 1'b0};
            r_j_den  <= r_i_b4;
        end
    end

    // pressure divider: b7 * 2 / b4, or b7 / b4 when b7 bit 31 is set
    logic [31:0]                          d2_quo;
    logic [$bits(bpc_pkg::t_d2_side)-1:0] d2_side_raw;
    bpc_pkg::t_d2_side                    d2_side;

    bpc_div_pipe #(
        .NUM_W  (bpc_pkg::DIV2_NUM_W),
        .DEN_W  (bpc_pkg::DIV_DEN_W),
        .SIDE_W ($bits(bpc_pkg::t_d2_side))
    ) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_j_vld),
        .i_num   (r_j_num),
        .i_den   (r_j_den),
        .i_side  (r_j_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side_raw)
    );

    assign d2_side = d2_side_raw;

    // stage k: raw pressure p
    logic signed [31:0] r_k_p;
    logic signed [15:0] r_k_t;
    logic               r_k_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_p   <= d2_side.big ? $signed({d2_quo[30:0], 1'b0}) : $signed(d2_quo);
            r_k_t   <= d2_side.t;
            r_k_err <= d2_side.err;
        end
    end

    // stage l: (p >> 8) squared, -7357 * p
    logic signed [31:0] l_x1;
    logic signed [31:0] r_l_sq, r_l_m, r_l_p;
    logic signed [15:0] r_l_t;
    logic               r_l_err;

    assign l_x1 = r_k_p >>> 8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_sq  <= l_x1 * l_x1;
            r_l_m   <= bpc_pkg::C_K2 * r_k_p;
            r_l_p   <= r_k_p;
            r_l_t   <= r_k_t;
            r_l_err <= r_k_err;
        end
    end

    // stage m: scale by 3038
    logic signed [31:0] r_m_m1, r_m_x2, r_m_p;
    logic signed [15:0] r_m_t;
    logic               r_m_err;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_m1  <= r_l_sq * bpc_pkg::C_K1;
            r_m_x2  <= r_l_m >>> 16;
            r_m_p   <= r_l_p;
            r_m_t   <= r_l_t;
            r_m_err <= r_l_err;
        end
    end

    // stage n: final correction, saturation, output register
    logic signed [31:0] n_s, n_p;
    logic [19:0]        n_pres;
    logic signed [15:0] r_o_t;
    logic [19:0]        r_o_p;
    logic               r_o_err;

    always_comb begin
        n_s = (r_m_m1 >>> 16) + r_m_x2 + bpc_pkg::C_K3;
        n_p = r_m_p + (n_s >>> 4);
        if (n_p < 32'sd0) begin
            n_pres = '0;
        end else if (n_p > bpc_pkg::C_P_MAX) begin
            n_pres = '1;
        end else begin
            n_pres = n_p[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_t   <= r_m_err ? 16'sd0 : r_m_t;
            r_o_p   <= r_m_err ? 20'd0 : n_pres;
            r_o_err <= r_m_err;
        end
    end

    assign o_valid                   = r_o_vld;
    assign o_temperature_decidegrees = r_o_t;
    assign o_pressure_pascal         = r_o_p;
    assign o_divide_error            = r_o_err;

endmodule

// ===== rtl/bpc_div_pipe.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
module bpc_div_pipe #(
    parameter int NUM_W  = bpc_pkg::DIV2_NUM_W,
    parameter int DEN_W  = bpc_pkg::DIV_DEN_W,
    parameter int SIDE_W = $bits(bpc_pkg::t_d2_side)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic              r_vld  [NUM_W];

    logic [DEN_W-1:0]  s_rem  [NUM_W];
    logic [NUM_W-1:0]  s_num  [NUM_W];
    logic [DEN_W-1:0]  s_den  [NUM_W];
    logic [SIDE_W-1:0] s_side [NUM_W];
    logic              s_vld  [NUM_W];

    logic [DEN_W:0]    n_sh   [NUM_W];
    logic [DEN_W:0]    n_sub  [NUM_W];
    logic              n_ge   [NUM_W];

    // stage inputs: first stage from the ports, others from the previous stage
    always_comb begin
        s_rem[0]  = '0;
        s_num[0]  = i_num;
        s_den[0]  = i_den;
        s_side[0] = i_side;
        s_vld[0]  = i_valid;
        for (int s = 1; s < NUM_W; s++) begin
            s_rem[s]  = r_rem[s-1];
            s_num[s]  = r_num[s-1];
            s_den[s]  = r_den[s-1];
            s_side[s] = r_side[s-1];
            s_vld[s]  = r_vld[s-1];
        end
    end

    // shift in the next dividend bit, trial subtract
    always_comb begin
        for (int s = 0; s < NUM_W; s++) begin
            n_sh[s]  = {s_rem[s], s_num[s][NUM_W-1]};
            n_sub[s] = n_sh[s] - {1'b0, s_den[s]};
            n_ge[s]  = (n_sh[s] >= {1'b0, s_den[s]});
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_W; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < NUM_W; s++) r_vld[s] <= s_vld[s];
        end
    end

    // partial remainder, dividend / quotient shift register, divisor, sideband
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_rem[s]  <= n_ge[s] ? n_sub[s][DEN_W-1:0] : n_sh[s][DEN_W-1:0];
                r_num[s]  <= {s_num[s][NUM_W-2:0], n_ge[s]};
                r_den[s]  <= s_den[s];
                r_side[s] <= s_side[s];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_num[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// ===== rtl/bpc_checker.sv =====
// port-level checks for the barometric pressure compensation top, with bind
module bpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [bpc_pkg::RAW_T_W-1:0]       i_raw_temperature,
    input logic [bpc_pkg::RAW_P_W-1:0]       i_raw_pressure,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [bpc_pkg::TEMP_W-1:0] o_temperature_decidegrees,
    input logic [bpc_pkg::PRES_W-1:0]        o_pressure_pascal,
    input logic                              o_divide_error
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature_decidegrees)
            && $stable(o_pressure_pascal) && $stable(o_divide_error))
        else $error("output beat changed while stalled");

    // input is held back only by a stalled output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // a divide error zeroes both values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_temperature_decidegrees == 16'sd0
            && o_pressure_pascal == 20'd0)
        else $error("divide error with nonzero result");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);

// ===== bench/tb_barometric_pressure_compensation_top.sv =====
// self-checking testbench for the barometric pressure compensation block
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] temp;
    logic [19:0]        pres;
    logic               err;
} comp_result_t;

// holds the coefficient copy, predicts each accepted beat and checks results
class comp_scoreboard;
    logic [47:0] ac_signed;
    logic [47:0] ac_unsigned;
    logic [31:0] b_coefs;
    logic [31:0] m_coefs;
    logic [1:0]  oss;
    comp_result_t pending[$];
    int mismatches;

    function new();
        ac_signed   = '0;
        ac_unsigned = '0;
        b_coefs     = '0;
        m_coefs     = '0;
        oss         = '0;
        mismatches  = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [47:0] data);
        case (idx)
            bpc_pkg::CFG_AC1_AC2_AC3: ac_signed   = data;
            bpc_pkg::CFG_AC4_AC5_AC6: ac_unsigned = data;
            bpc_pkg::CFG_B1_B2:       b_coefs     = data[31:0];
            bpc_pkg::CFG_MC_MD:       m_coefs     = data[31:0];
            bpc_pkg::CFG_OSS:         oss         = data[1:0];
            default: ;
        endcase
    endfunction

    // wrap to a signed 32-bit word
    static function longint w32(longint v);
        logic [31:0] u;
        u = v[31:0];
        return longint'($signed(u));
    endfunction

    function comp_result_t compensate(logic [15:0] ut_in, logic [18:0] up_in);
        comp_result_t r;
        longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint ut, x1, x2, x3, den, b5, b6, sq, b3, t, p;
        logic [31:0] ua, ub, b4, b7, pu, upw;
        ac1 = longint'($signed(ac_signed[47:32]));
        ac2 = longint'($signed(ac_signed[31:16]));
        ac3 = longint'($signed(ac_signed[15:0]));
        ac4 = longint'(ac_unsigned[47:32]);
        ac5 = longint'(ac_unsigned[31:16]);
        ac6 = longint'(ac_unsigned[15:0]);
        b1  = longint'($signed(b_coefs[31:16]));
        b2  = longint'($signed(b_coefs[15:0]));
        mc  = longint'($signed(m_coefs[31:16]));
        md  = longint'($signed(m_coefs[15:0]));
        ut  = longint'(ut_in);
        upw = 32'(up_in);
        r.temp = '0;
        r.pres = '0;
        r.err  = 1'b1;
        // temperature term
        x1  = w32((ut - ac6) * ac5) >>> 15;
        den = w32(x1 + md);
        if (den == 0) return r;
        x2 = w32((mc * 2048) / den);
        b5 = w32(x1 + x2);
        // pressure offset and scale
        b6 = w32(b5 - 4000);
        sq = w32(b6 * b6) >>> 12;
        x1 = w32(b2 * sq) >>> 11;
        x2 = w32(ac2 * b6) >>> 11;
        x3 = w32(x1 + x2);
        b3 = w32(w32(ac1 * 4 + x3) * (longint'(1) << oss));
        b3 = w32(b3 + 2) / 4;
        x1 = w32(ac3 * b6) >>> 13;
        x2 = w32(b1 * sq) >>> 16;
        x3 = w32(x1 + x2 + 2) >>> 2;
        ua = ac4[31:0];
        ub = 32'(x3 + 32768);
        b4 = (ua * ub) >> 15;
        if (b4 == 0) return r;
        ub = b3[31:0];
        b7 = (upw - ub) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
        else pu = (b7 / b4) * 32'd2;
        p = longint'($signed(pu));
        // second-order correction
        x1 = p >>> 8;
        x1 = w32(x1 * x1);
        x1 = w32(x1 * 3038) >>> 16;
        x2 = w32(-7357 * p) >>> 16;
        p  = w32(p + (w32(x1 + x2 + 3791) >>> 4));
        t  = w32(b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        r.temp = t[15:0];
        r.pres = p[19:0];
        r.err  = 1'b0;
        return r;
    endfunction

    function void note_input(logic [15:0] ut_in, logic [18:0] up_in);
        pending.push_back(compensate(ut_in, up_in));
    endfunction

    function void check_result(comp_result_t got);
        comp_result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat t=%0d p=%0d e=%0d",
                         got.temp, got.pres, got.err);
            return;
        end
        want = pending.pop_front();
        if (got.temp !== want.temp || got.pres !== want.pres || got.err !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected t=%0d p=%0d e=%0d, got t=%0d p=%0d e=%0d",
                         want.temp, want.pres, want.err, got.temp, got.pres, got.err);
        end
    endfunction
endclass

module tb_barometric_pressure_compensation_top;

    localparam int CYCLE_LIMIT = 1500000;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                               i_valid;
    logic                               o_stall;
    logic [bpc_pkg::RAW_T_W-1:0]        i_raw_temperature;
    logic [bpc_pkg::RAW_P_W-1:0]        i_raw_pressure;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [bpc_pkg::TEMP_W-1:0]  o_temperature_decidegrees;
    logic [bpc_pkg::PRES_W-1:0]         o_pressure_pascal;
    logic                               o_divide_error;

    comp_scoreboard sb = new();
    int  cycles = 0;
    int  hold_left = 0;
    bit  sink_quiet = 0;
    bit  src_quiet = 0;

    barometric_pressure_compensation_top dut (.*);

    // clock and run limit
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result sink with random stall runs and a forced long hold-off
    initial begin
        int run;
        bit stall_now;
        run = 0;
        stall_now = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run == 0) begin
                    stall_now = !sink_quiet && ($urandom_range(0, 3) == 0);
                    run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
                end
                run--;
                i_stall <= stall_now;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        comp_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.temp = o_temperature_decidegrees;
            got.pres = o_pressure_pascal;
            got.err  = o_divide_error;
            sb.check_result(got);
        end
    end

    task automatic send_reading(logic [15:0] ut, logic [18:0] up);
        int gap;
        i_valid           <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure    <= up;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(ut, up);
        gap = 0;
        if (!src_quiet && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // writes every register plus the unused indexes, then drops the enable
    task automatic load_coefs(logic [47:0] r0, logic [47:0] r1, logic [31:0] r2,
                              logic [31:0] r3, logic [1:0] os);
        logic [47:0] vals [8];
        vals[0] = r0;
        vals[1] = r1;
        vals[2] = 48'({$urandom(), $urandom()}) & 48'hFFFF_0000_0000 | 48'(r2);
        vals[3] = 48'({$urandom(), $urandom()}) & 48'hFFFF_0000_0000 | 48'(r3);
        vals[4] = 48'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_FFFC | 48'(os);
        for (int i = 5; i < 8; i++) vals[i] = 48'({$urandom(), $urandom()});
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.set_register(i[2:0], vals[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // typical factory coefficients with optional spread
    task automatic load_typical(logic [1:0] os, int spread);
        logic [15:0] c [11];
        c[0] = 408;   c[1] = -72;   c[2] = -14383; c[3] = 32741;
        c[4] = 32757; c[5] = 23153; c[6] = 6190;   c[7] = 4;
        c[8] = -8711; c[9] = 2868;
        for (int i = 0; i < 10; i++)
            if (spread > 0)
                c[i] = 16'(int'(c[i]) + int'($urandom_range(0, 2 * spread)) - spread);
        load_coefs({c[0], c[1], c[2]}, {c[3], c[4], c[5]}, {c[6], c[7]},
                   {c[8], c[9]}, os);
    endtask

    task automatic random_readings(int n, logic [1:0] os);
        logic [15:0] ut;
        logic [18:0] up;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) != 0) begin
                ut = 16'($urandom_range(15000, 40000));
                up = 19'($urandom_range(20000, 45000) << os);
            end else begin
                ut = 16'($urandom());
                up = 19'($urandom());
            end
            if (i % 60 == 30) src_quiet = ~src_quiet;
            if (i % 80 == 40) sink_quiet = ~sink_quiet;
            send_reading(ut, up);
        end
        src_quiet = 0;
        sink_quiet = 0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_wdata       <= '0;
        i_valid           <= 1'b0;
        i_raw_temperature <= '0;
        i_raw_pressure    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: zero divisor path
        send_reading(16'd27898, 19'd23843);
        send_reading(16'hFFFF, 19'h7FFFF);
        wait_drained();

        // directed readings on typical coefficients, every oversampling
        for (int os = 0; os < 4; os++) begin
            load_typical(os[1:0], 0);
            send_reading(16'd27898, 19'd23843 << os);
            send_reading(16'd0, 19'd0);
            send_reading(16'hFFFF, 19'h7FFFF);
            send_reading(16'd0, 19'h7FFFF);
            send_reading(16'hFFFF, 19'd0);
            wait_drained();
        end

        // saturated coefficient words
        load_coefs('1, '1, '1, '1, 2'd3);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'h8000, 19'h40000);
        wait_drained();

        // long sink hold-off while the source keeps offering beats
        load_typical(2'd1, 50);
        hold_left = 400;
        src_quiet = 1;
        random_readings(150, 2'd1);
        wait_drained();

        // random phases over several coefficient sets
        for (int ph = 0; ph < 10; ph++) begin
            logic [1:0] os;
            os = 2'(ph % 4);
            case (ph % 5)
                0: load_typical(os, 0);
                1: load_typical(os, 200);
                2: load_typical(os, 2000);
                3: load_coefs(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                              $urandom(), $urandom(), os);
                default: load_coefs('0, {16'd32741, 16'd32757, 16'd23153},
                                    {16'd6190, 16'd4}, {16'hDDF9, 16'd0}, os);
            endcase
            random_readings(170, os);
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
